>>> rtl/core/hfas_pkg.sv
package hfas_pkg;

  localparam logic [15:0] SgnBit  = 16'h8000;
  localparam logic [15:0] ExpBits = 16'h7C00;
  localparam logic [15:0] QnanOut = 16'h7FFF;
  localparam logic [15:0] DExp    = 16'hF800;

  // Stage 1 -> stage 2: swapped operands and aligned mantissa.
  typedef struct packed {
    logic        is_sub;
    logic        done;     // result already final
    logic [15:0] res;      // final result when done
    logic [15:0] sign;
    logic [15:0] a;        // larger magnitude (sub: shifted left by one)
    logic [15:0] bm;       // aligned smaller mantissa
  } s1_t;

  // Stage 2 -> stage 3: final result or raw difference, ready for normalization.
  typedef struct packed {
    logic        done;
    logic [15:0] res;
    logic [15:0] sign;
    logic [15:0] ax;
    logic [15:0] nm;
  } s2_t;

endpackage

>>> rtl/core/hfas_if.sv
interface hfas_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] a_value;
  logic [15:0] b_value;
  modport source (output valid, op, a_value, b_value, input ready);
  modport sink   (input valid, op, a_value, b_value, output ready);
endinterface

interface hfas_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sum_value;
  modport source (output valid, sum_value, input ready);
  modport sink   (input valid, sum_value, output ready);
endinterface

>>> rtl/core/half_float_add_sub.sv
// Truncating binary16 adder/subtractor.
// Input channel in_if carries op (0: a+b, 1: a-b), a_value and b_value;
// output channel out_if carries sum_value. A beat is taken when valid and
// ready are both high.
// The unit is a three-stage pipeline: alignment, add or subtract, then
// leading-zero normalization. A beat passes through the s1_q, s2_q and res_q
// registers in turn before it shows up on out_if; throughput is one beat
// per cycle while the sink keeps up.
// Each stage holds its own valid bit. When the sink stalls, stages fill up
// from the output backwards; a stage advances whenever the stage after it
// is empty or moving, so no beat is lost or repeated.
// Reset clears the valid bits only; the data registers are not reset.
// NaN inputs and infinity minus infinity give 0x7FFF; overflow gives a
// signed infinity; exact cancellation gives +0.
module half_float_add_sub (
  input  logic clk_i,
  input  logic rst_ni,
  hfas_in_if.sink    in_if,
  hfas_out_if.source out_if
);
  hfas_pkg::s1_t s1_d, s1_q;
  hfas_pkg::s2_t s2_d, s2_q;
  logic [15:0]   res_d, res_q;
  logic          v1_q, v2_q, v3_q;
  logic          adv1, adv2, adv3;

  hfas_align   u_align   (.op_i(in_if.op), .a_i(in_if.a_value), .b_i(in_if.b_value),
                          .s1_o(s1_d));
  hfas_combine u_combine (.s1_i(s1_q), .s2_o(s2_d));
  hfas_norm    u_norm    (.s2_i(s2_q), .res_o(res_d));

  // Advance each stage when the one downstream can take it.
  assign adv3 = !v3_q || out_if.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_if.ready = adv1;
  assign out_if.valid = v3_q;
  assign out_if.sum_value = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_if.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
    if (adv2) s2_q <= s2_d;
    if (adv3) res_q <= res_d;
  end

  // Hold output while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.sum_value))
    else $error("output changed under stall");
  // A full pipe with stalled sink refuses input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && !out_if.ready |-> !in_if.ready)
    else $error("accepted into full pipe");
  // An accepted beat reaches stage one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> v1_q)
    else $error("beat lost at entry");
endmodule

>>> rtl/core/hfas_align.sv
module hfas_align (
  input  logic            op_i,
  input  logic [15:0]     a_i,
  input  logic [15:0]     b_i,
  output hfas_pkg::s1_t   s1_o
);
  logic [15:0] a0, b0, aa, bb, ax, bx, bmf, sh;
  logic        op, swap;

  always_comb begin
    op = op_i;
    b0 = b_i;
    if (((a_i ^ b_i) & hfas_pkg::SgnBit) != 16'd0) begin
      b0 = b_i ^ hfas_pkg::SgnBit;
      op = ~op_i;
    end
    s1_o = '0;
    s1_o.is_sub = op;
    s1_o.sign = a_i & hfas_pkg::SgnBit;
    bmf = '0;
    sh = '0;
    ax = '0;
    bx = '0;
    if (!op) begin
      a0 = a_i & 16'h7FFF;
      b0 = b0 & 16'h7FFF;
      swap = a0 < b0;
      aa = swap ? b0 : a0;
      bb = swap ? a0 : b0;
      if (aa >= hfas_pkg::ExpBits) begin
        s1_o.done = 1'b1;
        s1_o.res = (aa > hfas_pkg::ExpBits || bb > hfas_pkg::ExpBits) ? hfas_pkg::QnanOut
                   : (s1_o.sign | hfas_pkg::ExpBits);
      end
      ax = aa & hfas_pkg::ExpBits;
      bx = bb & hfas_pkg::ExpBits;
      if (ax != bx) begin
        sh = (ax - bx) >> 10;
        if (bx != 16'd0) bmf = (bb & 16'd1023) | 16'd1024;
        else begin
          bmf = bb;
          sh = sh - 16'd1;
        end
      end else begin
        bmf = (bb & 16'd1023) | 16'd1024;
        if (bx == 16'd0 && !s1_o.done) begin
          s1_o.done = 1'b1;
          s1_o.res = (aa + bb) | s1_o.sign;
        end
      end
    end else begin
      a0 = {a_i[14:0], 1'b0};
      b0 = {b0[14:0], 1'b0};
      swap = a0 < b0;
      aa = swap ? b0 : a0;
      bb = swap ? a0 : b0;
      if (swap) s1_o.sign = s1_o.sign ^ hfas_pkg::SgnBit;
      if (aa >= hfas_pkg::DExp) begin
        s1_o.done = 1'b1;
        s1_o.res = (aa > hfas_pkg::DExp || aa == bb) ? hfas_pkg::QnanOut
                   : (s1_o.sign | hfas_pkg::ExpBits);
      end
      ax = aa & hfas_pkg::DExp;
      bx = bb & hfas_pkg::DExp;
      if (ax != bx) begin
        sh = (ax - bx) >> 11;
        if (bx != 16'd0) bmf = (bb & 16'd2047) | 16'd2048;
        else begin
          bmf = bb;
          sh = sh - 16'd1;
        end
      end else begin
        bmf = (bb & 16'd2047) | 16'd2048;
        if (bx == 16'd0 && !s1_o.done) begin
          s1_o.done = 1'b1;
          s1_o.res = ((aa - bb) >> 1) == 16'd0 ? 16'd0 : (((aa - bb) >> 1) | s1_o.sign);
        end
      end
    end
    s1_o.a = aa;
    s1_o.bm = (sh < 16'd16) ? (bmf >> sh[3:0]) : 16'd0;
  end
endmodule

>>> rtl/core/hfas_combine.sv
module hfas_combine (
  input  hfas_pkg::s1_t s1_i,
  output hfas_pkg::s2_t s2_o
);
  logic [15:0] s, e, r, am;

  always_comb begin
    s2_o = '0;
    s2_o.done = s1_i.done;
    s2_o.res = s1_i.res;
    s2_o.sign = s1_i.sign;
    s = '0;
    e = '0;
    r = '0;
    am = '0;
    if (!s1_i.is_sub) begin
      am = (s1_i.a & 16'd1023) | 16'd1024;
      s = am + s1_i.bm;
      e = s1_i.a & hfas_pkg::ExpBits;
      if (s >= 16'd2048) begin
        e = e + 16'h0400;
        s = s >> 1;
      end
      r = e | (s & 16'd1023);
      if (!s1_i.done) begin
        s2_o.done = 1'b1;
        s2_o.res = (r >= hfas_pkg::ExpBits) ? (s1_i.sign | hfas_pkg::ExpBits)
                   : (s1_i.sign | r);
      end
    end else begin
      s2_o.ax = s1_i.a & hfas_pkg::DExp;
      r = s1_i.a - s1_i.bm;
      s2_o.nm = ((s1_i.a & 16'd2047) | 16'd2048) - s1_i.bm;
      if (!s1_i.done) begin
        if ((r & hfas_pkg::DExp) == s2_o.ax) begin
          s2_o.done = 1'b1;
          s2_o.res = (r >> 1) | s1_i.sign;
        end else if (s2_o.nm == 16'd0) begin
          s2_o.done = 1'b1;
          s2_o.res = 16'd0;
        end
      end
    end
  end
endmodule

>>> rtl/core/hfas_norm.sv
module hfas_norm (
  input  hfas_pkg::s2_t s2_i,
  output logic [15:0]   res_o
);
  logic [3:0]  lz;
  logic [4:0]  ex, shv;
  logic [15:0] nm;

  always_comb begin
    // Leading zeros above the hidden bit (nm < 4096 here).
    lz = 4'd11;
    for (int i = 0; i <= 11; i++) begin
      if (s2_i.nm[i]) lz = 4'(11 - i);
    end
    ex = s2_i.ax[15:11];
    // Shift until hidden bit or exponent reaches the subnormal level.
    if ({1'b0, lz} < ex) shv = {1'b0, lz};
    else shv = ex - 5'd1;
    nm = s2_i.nm << shv;
    if (s2_i.done) res_o = s2_i.res;
    else res_o = ((((nm & 16'd2047) | {ex - shv - (({1'b0, lz} < ex) ? 5'd0 : 5'd1),
                 11'd0})) >> 1) | s2_i.sign;
  end
endmodule
